### rtl/core/vear_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vear_pkg
// Shared types and constants for the vector element-wise and reduction unit.
// ----------------------------------------------------------------------------
package vear_pkg;

   // operand and result widths
   localparam int OP_W    = 33;   // sign-extended element, element difference or scale factor
   localparam int PROD_W  = 2 * OP_W;
   localparam int ACC_W   = 64;
   localparam int ROOT_W  = ACC_W / 2;
   localparam int CFG_W   = 32;
   localparam int MODE_W  = 3;
   localparam int CSR_IDX_W = 1;

   // fraction bits of the Q16.16 scale factor; the scale product is shifted right by this
   localparam int FRAC_BITS = 16;

   // operation modes
   localparam logic [MODE_W-1:0] MODE_ADD   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SUB   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SCALE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DOT   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_NORM  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_DIST  = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MODE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE = 1'b1;

   // reset values
   localparam logic [MODE_W-1:0] MODE_RESET  = MODE_DOT;
   localparam logic [CFG_W-1:0]  SCALE_RESET = 32'h0001_0000;

   // controller to datapath commands
   typedef struct packed {
      logic capture;     // latch operands of the accepted transaction
      logic mul;         // register the product
      logic exec;        // element result or accumulator update
      logic root_start;  // launch the square root on the final sum
      logic load_out;    // move the finished result into the output register
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic elem_mode;
      logic dot_mode;
      logic root_mode;
      logic last;
      logic root_done;
      logic out_free;
   } status_type;

endpackage

### rtl/core/vear_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vear_sqrt
// Iterative floor square root of a 64-bit unsigned value, one root bit a cycle.
// ----------------------------------------------------------------------------
module vear_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [vear_pkg::ACC_W-1:0]  operand,
   output logic                        done,
   output logic [vear_pkg::ROOT_W-1:0] root
);

   localparam int REM_W = vear_pkg::ROOT_W + 3;
   localparam int CNT_W = $clog2(vear_pkg::ROOT_W);

   logic [vear_pkg::ACC_W-1:0]  x_ff, x_in;
   logic [REM_W-1:0]            rem_ff, rem_in;
   logic [vear_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [REM_W-1:0]            rem_sh;
   logic [REM_W-1:0]            trial;
   logic                        fits;

   // one restoring step: bring down two bits, try root*4+1
   always_comb begin
      rem_sh = {rem_ff[REM_W-3:0], x_ff[vear_pkg::ACC_W-1 -: 2]};
      trial  = {1'b0, root_ff, 2'b01};
      fits   = (rem_sh >= trial);
      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = operand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         x_in    = {x_ff[vear_pkg::ACC_W-3:0], 2'b00};
         rem_in  = fits ? (rem_sh - trial) : rem_sh;
         root_in = {root_ff[vear_pkg::ROOT_W-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(vear_pkg::ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

   // a new root is never launched over one in flight
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("square root started while busy");

   // done follows the final step
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ($past(busy_ff) && !busy_ff))
      else $error("square root done without a running iteration");

endmodule

### rtl/core/vear_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vear_datapath
// Config registers, operand capture, multiplier, accumulator, root unit and
// output register.
// ----------------------------------------------------------------------------
module vear_datapath #(
   parameter int ELEM_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  vear_pkg::cmd_type                    cmd,
   output vear_pkg::status_type                 status,
   input  logic signed [ELEM_WIDTH-1:0]         req_elem_a,
   input  logic signed [ELEM_WIDTH-1:0]         req_elem_b,
   input  logic                                 req_last_elem,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [vear_pkg::ACC_W-1:0]    rsp_value,
   output logic                                 rsp_is_last,
   output logic                                 rsp_saturated,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [vear_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [vear_pkg::CFG_W-1:0]           csr_data
);

   localparam int OP_W  = vear_pkg::OP_W;
   localparam int ACC_W = vear_pkg::ACC_W;
   localparam int EXT_W = OP_W - ELEM_WIDTH;
   localparam logic signed [ACC_W-1:0] ELEM_MAX = (64'sd1 <<< (ELEM_WIDTH - 1)) - 64'sd1;
   localparam logic signed [ACC_W-1:0] ELEM_MIN = -ELEM_MAX - 64'sd1;
   localparam logic signed [ACC_W-1:0] RND_HALF = 64'sd1 <<< (vear_pkg::FRAC_BITS - 1);
   localparam logic [ACC_W-1:0] SMAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0] SMIN = {1'b1, {(ACC_W-1){1'b0}}};

   // configuration registers
   logic [vear_pkg::MODE_W-1:0] mode_ff;
   logic [vear_pkg::CFG_W-1:0]  scale_ff;

   // operand and product registers
   logic signed [OP_W-1:0]      op_x_ff, op_x_in;
   logic signed [OP_W-1:0]      op_y_ff, op_y_in;
   logic                        last_ff;
   logic [ACC_W-1:0]            prod_ff;
   logic signed [vear_pkg::PROD_W-1:0] prod_full;

   // accumulator
   logic [ACC_W-1:0]            acc_ff, acc_in, acc_next;
   logic                        ovf_ff, ovf_in, ovf_next;

   // result staging and output register
   logic [ACC_W-1:0]            res_value_ff, res_value_in;
   logic                        res_last_ff, res_last_in;
   logic                        res_sat_ff, res_sat_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ACC_W-1:0]            rsp_value_ff;
   logic                        rsp_last_ff;
   logic                        rsp_sat_ff;

   // decode and element arithmetic
   logic                        elem_mode, dot_mode, root_mode;
   logic signed [OP_W-1:0]      a_ext, b_ext, s_ext, diff;
   logic signed [OP_W-1:0]      sum_sd;
   logic signed [ACC_W-1:0]     prod_s, rnd, shr, elem_raw;
   logic [ACC_W-1:0]            elem_val;
   logic                        elem_sat;
   logic [ACC_W-1:0]            dot_sum;
   logic [ACC_W:0]              usum;
   logic                        dot_ovf;

   logic                        root_done;
   logic [vear_pkg::ROOT_W-1:0] root_val;

   // mode decode
   always_comb begin
      elem_mode = 1'b0;
      dot_mode  = 1'b0;
      root_mode = 1'b0;
      unique case (mode_ff) inside
         vear_pkg::MODE_ADD, vear_pkg::MODE_SUB, vear_pkg::MODE_SCALE: elem_mode = 1'b1;
         vear_pkg::MODE_DOT:                                         dot_mode  = 1'b1;
         vear_pkg::MODE_NORM, vear_pkg::MODE_DIST:                   root_mode = 1'b1;
         default: ;
      endcase
   end

   // configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= vear_pkg::MODE_RESET;
         scale_ff <= vear_pkg::SCALE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            vear_pkg::REG_MODE:  mode_ff  <= csr_data[vear_pkg::MODE_W-1:0];
            vear_pkg::REG_SCALE: scale_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // operand selection at capture
   always_comb begin
      a_ext = {{EXT_W{req_elem_a[ELEM_WIDTH-1]}}, req_elem_a};
      b_ext = {{EXT_W{req_elem_b[ELEM_WIDTH-1]}}, req_elem_b};
      s_ext = {scale_ff[vear_pkg::CFG_W-1], scale_ff};
      diff  = a_ext - b_ext;
      op_x_in = a_ext;
      op_y_in = b_ext;
      case (mode_ff)
         vear_pkg::MODE_SCALE: op_y_in = s_ext;
         vear_pkg::MODE_NORM:  op_y_in = a_ext;
         vear_pkg::MODE_DIST: begin
            op_x_in = diff;
            op_y_in = diff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_x_ff <= op_x_in;
         op_y_ff <= op_y_in;
         last_ff <= req_last_elem;
      end
   end

   // multiplier stage
   assign prod_full = op_x_ff * op_y_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= prod_full[ACC_W-1:0];
      end
   end

   // element-wise result with saturation
   always_comb begin
      sum_sd = (mode_ff == vear_pkg::MODE_SUB) ? (op_x_ff - op_y_ff) : (op_x_ff + op_y_ff);
      prod_s = $signed(prod_ff);
      rnd    = prod_s + RND_HALF;
      shr    = rnd >>> vear_pkg::FRAC_BITS;
      if (mode_ff == vear_pkg::MODE_SCALE) begin
         elem_raw = shr;
      end else begin
         elem_raw = {{(ACC_W-OP_W){sum_sd[OP_W-1]}}, sum_sd};
      end
      elem_sat = 1'b0;
      elem_val = elem_raw;
      if (elem_raw > ELEM_MAX) begin
         elem_val = ELEM_MAX;
         elem_sat = 1'b1;
      end else if (elem_raw < ELEM_MIN) begin
         elem_val = ELEM_MIN;
         elem_sat = 1'b1;
      end
   end

   // accumulator update: signed for dot product, unsigned for sums of squares
   always_comb begin
      dot_sum  = acc_ff + prod_ff;
      dot_ovf  = (acc_ff[ACC_W-1] == prod_ff[ACC_W-1]) &&
                 (dot_sum[ACC_W-1] != acc_ff[ACC_W-1]);
      usum     = {1'b0, acc_ff} + {1'b0, prod_ff};
      acc_next = acc_ff;
      ovf_next = ovf_ff;
      if (dot_mode) begin
         acc_next = dot_ovf ? (acc_ff[ACC_W-1] ? SMIN : SMAX) : dot_sum;
         ovf_next = ovf_ff | dot_ovf;
      end else if (root_mode) begin
         acc_next = usum[ACC_W] ? {ACC_W{1'b1}} : usum[ACC_W-1:0];
         ovf_next = ovf_ff | usum[ACC_W];
      end
   end

   // accumulator and result staging
   always_comb begin
      acc_in       = acc_ff;
      ovf_in       = ovf_ff;
      res_value_in = res_value_ff;
      res_last_in  = res_last_ff;
      res_sat_in   = res_sat_ff;
      if (cmd.exec) begin
         if (elem_mode) begin
            res_value_in = elem_val;
            res_last_in  = last_ff;
            res_sat_in   = elem_sat;
         end else if (dot_mode || root_mode) begin
            acc_in = acc_next;
            ovf_in = ovf_next;
            if (last_ff) begin
               acc_in       = '0;
               ovf_in       = 1'b0;
               res_value_in = acc_next;
               res_last_in  = 1'b1;
               res_sat_in   = ovf_next;
            end
         end
      end else if (root_done) begin
         res_value_in = {{(ACC_W-vear_pkg::ROOT_W){1'b0}}, root_val};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         ovf_ff <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      res_value_ff <= res_value_in;
      res_last_ff  <= res_last_in;
      res_sat_ff   <= res_sat_in;
   end

   // square root unit
   vear_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.root_start),
      .operand (acc_next),
      .done    (root_done),
      .root    (root_val)
   );

   // output register
   assign rsp_valid_in = cmd.load_out ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_value_ff <= res_value_ff;
         rsp_last_ff  <= res_last_ff;
         rsp_sat_ff   <= res_sat_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = $signed(rsp_value_ff);
   assign rsp_is_last   = rsp_last_ff;
   assign rsp_saturated = rsp_sat_ff;

   // status to controller
   always_comb begin
      status.elem_mode = elem_mode;
      status.dot_mode  = dot_mode;
      status.root_mode = root_mode;
      status.last      = last_ff;
      status.root_done = root_done;
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // a finished reduction leaves a clean accumulator
   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && (dot_mode || root_mode) && last_ff) |=> (acc_ff == '0 && !ovf_ff))
      else $error("accumulator not cleared after reduction result");

endmodule

### rtl/core/vear_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vear_ctrl
// Sequencer: capture, multiply, execute, optional square root, hand-off.
// ----------------------------------------------------------------------------
module vear_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  vear_pkg::status_type status,
   output vear_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_EXEC = 3'd2;
   localparam logic [2:0] ST_ROOT = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_IDLE;
            if (status.elem_mode) begin
               state_in = ST_OUT;
            end else if (status.dot_mode && status.last) begin
               state_in = ST_OUT;
            end else if (status.root_mode && status.last) begin
               cmd.root_start = 1'b1;
               state_in       = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (status.root_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // the output register is only reloaded once its transaction has left
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.out_free)
      else $error("output register overwritten while pending");

   // no new transaction is taken while a root is being computed
   a_root_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT) |=> !$past(cmd.capture))
      else $error("capture during square root");

endmodule

### rtl/core/vector_elementwise_and_reduction.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_elementwise_and_reduction
// Streaming Q16.16 vector unit: add, subtract, scale, dot product, norm and
// distance over paired elements.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one element pair (a, b) and a last marker per transaction.
//   rsp_* returns results: one per element in add, subtract and scale modes,
//   one per vector (after the last element) in dot, norm and distance modes.
//   csr_* writes the mode register (index 0) and the scale factor (index 1);
//   write only while no transaction is in flight.
// Sequence:
//   An element passes capture, multiply and execute stages: a non-final
//   reduction element then ends, an element-wise result is then loaded into
//   the output register, and the next element can be accepted only after
//   that. Dot product results take the same path. Norm and distance first
//   run the bit-serial square root, which produces one root bit per cycle.
// Reset:
//   Mode returns to dot product, scale to 1.0, the accumulator and its
//   saturation flag to zero, and the output register empties.
// Stall:
//   A result waits in the output register while rsp_ready is low; the next
//   transaction is still taken and computed, then holds until the register
//   frees up.
// ----------------------------------------------------------------------------
module vector_elementwise_and_reduction #(
   parameter int ELEM_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [ELEM_WIDTH-1:0]       req_elem_a,
   input  logic signed [ELEM_WIDTH-1:0]       req_elem_b,
   input  logic                               req_last_elem,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [vear_pkg::ACC_W-1:0]  rsp_value,
   output logic                               rsp_is_last,
   output logic                               rsp_saturated,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [vear_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [vear_pkg::CFG_W-1:0]         csr_data
);

   vear_pkg::cmd_type    cmd;
   vear_pkg::status_type status;

   // sequencer
   vear_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and storage
   vear_datapath #(
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_elem_a    (req_elem_a),
      .req_elem_b    (req_elem_b),
      .req_last_elem (req_last_elem),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value     (rsp_value),
      .rsp_is_last   (rsp_is_last),
      .rsp_saturated (rsp_saturated),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

endmodule
